// ===== src/polar_cartesian_converter_unit_assert.svh =====
// Assertion macros used by the checker file of the polar/cartesian converter.
`ifndef POLAR_CARTESIAN_CONVERTER_UNIT_ASSERT_SVH
`define POLAR_CARTESIAN_CONVERTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcc_pkg.sv =====
// Shared constants, angle table and control struct of the polar/cartesian converter.
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

  // mode codes carried in func
  localparam logic FUNC_TO_POLAR = 1'b0;
  localparam logic FUNC_TO_CART  = 1'b1;

  localparam int GUARD  = 4;   // extra fraction bits on data inside the rotator
  localparam int ZW     = 34;  // angle accumulator width, Q.30 radians
  localparam int KFRAC  = 24;  // fraction bits of the gain constant
  localparam int KSPLIT = 12;  // gain multiply is cut into two partial products here

  localparam logic [KFRAC-1:0]        CORDIC_K = 24'd10188014;
  localparam logic [KFRAC-KSPLIT-1:0] K_HI     = CORDIC_K[KFRAC-1:KSPLIT];
  localparam logic [KSPLIT-1:0]       K_LO     = CORDIC_K[KSPLIT-1:0];

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam int ATAN_ENTRIES = 32;

  // atan(2^-i) in Q.30
  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic func;
    logic zero;   // cartesian input at the origin
  } ctl_t;

endpackage

`default_nettype wire

// ===== src/pcc_if.sv =====
// Valid/ready channel interfaces for the converter's input and result items.
`timescale 1ns / 1ps
`default_nettype none

interface pcc_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [DATA_WIDTH-1:0] first_operand;
  logic signed [DATA_WIDTH-1:0] second_operand;

  modport source (output valid, func, first_operand, second_operand, input ready);
  modport sink   (input valid, func, first_operand, second_operand, output ready);
endinterface

interface pcc_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] first_result;
  logic signed [DATA_WIDTH-1:0] second_result;

  modport source (output valid, first_result, second_result, input ready);
  modport sink   (input valid, first_result, second_result, output ready);
endinterface

`default_nettype wire

// ===== src/pcc_stage.sv =====
// One registered CORDIC micro-rotation stage.
`timescale 1ns / 1ps
`default_nettype none

module pcc_stage #(
  parameter int XW    = 23,
  parameter int STAGE = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  pcc_pkg::ctl_t                 ctl_in,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [XW-1:0]          y_in,
  input  logic signed [pcc_pkg::ZW-1:0] z_in,
  output pcc_pkg::ctl_t                 ctl_out,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic signed [pcc_pkg::ZW-1:0] z_out
);

  localparam int ZW = pcc_pkg::ZW;
  localparam logic signed [ZW-1:0] ATAN = ZW'({2'b00, pcc_pkg::ATAN_Q30[STAGE]});

  pcc_pkg::ctl_t        ctl_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt, dx, dy;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 turn_neg;

  always_comb begin
    dx = y_in >>> STAGE;
    dy = x_in >>> STAGE;
    // rotation: drive angle to zero, or drive y to zero
    if (ctl_in.func == pcc_pkg::FUNC_TO_CART) begin
      turn_neg = !z_in[ZW-1];
    end else begin
      turn_neg = y_in[XW-1];
    end
    if (turn_neg) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ATAN;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

`default_nettype wire

// ===== src/pcc_gain.sv =====
// Gain correction, rounding, saturation and result select over three stages.
`timescale 1ns / 1ps
`default_nettype none

module pcc_gain #(
  parameter int DATA_WIDTH = 16,
  parameter int XW         = 23
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  pcc_pkg::ctl_t                 ctl_in,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [XW-1:0]          y_in,
  input  logic signed [pcc_pkg::ZW-1:0] z_in,
  output pcc_pkg::ctl_t                 ctl_out,
  output logic signed [DATA_WIDTH-1:0]  first_out,
  output logic signed [DATA_WIDTH-1:0]  second_out
);

  localparam int ZW        = pcc_pkg::ZW;
  localparam int HW        = XW + pcc_pkg::KFRAC - pcc_pkg::KSPLIT + 1;
  localparam int LW        = XW + pcc_pkg::KSPLIT + 1;
  localparam int PW        = XW + pcc_pkg::KFRAC + 1;
  localparam int RS        = pcc_pkg::KFRAC + pcc_pkg::GUARD;
  localparam int ANG_SHIFT = 33 - DATA_WIDTH;

  localparam logic signed [HW-1:0] KH     = HW'({1'b0, pcc_pkg::K_HI});
  localparam logic signed [LW-1:0] KL     = LW'({1'b0, pcc_pkg::K_LO});
  localparam logic signed [PW-1:0] P_HALF = PW'(1) <<< (RS - 1);
  localparam logic signed [PW-1:0] P_MAX  = (PW'(1) <<< (DATA_WIDTH - 1)) - PW'(1);
  localparam logic signed [PW-1:0] P_MIN  = -(PW'(1) <<< (DATA_WIDTH - 1));
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(1) <<< (ANG_SHIFT - 1);
  localparam logic signed [ZW-1:0] Z_MAX  = (ZW'(1) <<< (DATA_WIDTH - 1)) - ZW'(1);
  localparam logic signed [ZW-1:0] Z_MIN  = -(ZW'(1) <<< (DATA_WIDTH - 1));

  function automatic logic signed [DATA_WIDTH-1:0] sat_p(input logic signed [PW-1:0] v);
    logic signed [DATA_WIDTH-1:0] r;
    if (v > P_MAX) begin
      r = P_MAX[DATA_WIDTH-1:0];
    end else if (v < P_MIN) begin
      r = P_MIN[DATA_WIDTH-1:0];
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_z(input logic signed [ZW-1:0] v);
    logic signed [DATA_WIDTH-1:0] r;
    if (v > Z_MAX) begin
      r = Z_MAX[DATA_WIDTH-1:0];
    end else if (v < Z_MIN) begin
      r = Z_MIN[DATA_WIDTH-1:0];
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

  // stage 1: partial products of x*K and y*K
  pcc_pkg::ctl_t        ctl1_r, ctl2_r, ctl3_r;
  logic signed [HW-1:0] px_hi_r, py_hi_r;
  logic signed [LW-1:0] px_lo_r, py_lo_r;
  logic signed [ZW-1:0] z1_r;
  // stage 2: full products, angle rounded to output scale
  logic signed [PW-1:0] px_r, py_r;
  logic signed [ZW-1:0] z2_r, z2_nxt;
  // stage 3: rounded, saturated, selected
  logic signed [PW-1:0] rx, ry;
  logic signed [DATA_WIDTH-1:0] first_r, second_r, first_nxt, second_nxt, sx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  assign z2_nxt = (z1_r + Z_HALF) >>> ANG_SHIFT;

  always_comb begin
    rx = (px_r + P_HALF) >>> RS;
    ry = (py_r + P_HALF) >>> RS;
    sx = sat_p(rx);
    if (ctl2_r.zero) begin
      first_nxt  = '0;
      second_nxt = '0;
    end else if (ctl2_r.func == pcc_pkg::FUNC_TO_CART) begin
      first_nxt  = sx;
      second_nxt = sat_p(ry);
    end else begin
      // magnitude never shows negative
      first_nxt  = sx[DATA_WIDTH-1] ? '0 : sx;
      second_nxt = sat_z(z2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_hi_r  <= HW'(x_in) * KH;
      px_lo_r  <= LW'(x_in) * KL;
      py_hi_r  <= HW'(y_in) * KH;
      py_lo_r  <= LW'(y_in) * KL;
      z1_r     <= z_in;
      px_r     <= (PW'(px_hi_r) <<< pcc_pkg::KSPLIT) + PW'(px_lo_r);
      py_r     <= (PW'(py_hi_r) <<< pcc_pkg::KSPLIT) + PW'(py_lo_r);
      z2_r     <= z2_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
    end
  end

  assign ctl_out    = ctl3_r;
  assign first_out  = first_r;
  assign second_out = second_r;

endmodule

`default_nettype wire

// ===== src/polar_cartesian_converter_unit.sv =====
// Top level: pipelined CORDIC converter between polar and cartesian form.
//
//   channel  | direction | handshake     | payload
//   in_ch    | in        | valid / ready | func, first_operand, second_operand
//   out_ch   | out       | valid / ready | first_result, second_result
//
// One item per clock enters while the skid entry is empty; a result passes through
// one setup stage, one stage per micro-rotation, three gain stages and the output register.
// Reset is synchronous on rst_n and clears the control and valid flags only.
// A two-entry output buffer lets items enter while a result waits; the pipeline
// freezes only when both entries are full.
`timescale 1ns / 1ps
`default_nettype none

module polar_cartesian_converter_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pcc_in_if.sink    in_ch,
  pcc_out_if.source out_ch
);

  localparam int ZW        = pcc_pkg::ZW;
  localparam int XW        = DATA_WIDTH + pcc_pkg::GUARD + 3;
  localparam int ANG_SHIFT = 33 - DATA_WIDTH;

  logic adv, push, pop;

  // ---- setup stage: scale, quadrant fold, origin flag
  logic signed [XW-1:0] a_x, b_y, x_nxt, y_nxt, x_p_r, y_p_r;
  logic signed [ZW-1:0] b_z, z_nxt, z_p_r;
  pcc_pkg::ctl_t        ctl_nxt, ctl_p_r;

  always_comb begin
    a_x = XW'(in_ch.first_operand) <<< pcc_pkg::GUARD;
    b_y = XW'(in_ch.second_operand) <<< pcc_pkg::GUARD;
    b_z = ZW'(in_ch.second_operand) <<< ANG_SHIFT;
    ctl_nxt.valid = in_ch.valid;
    ctl_nxt.func  = in_ch.func;
    ctl_nxt.zero  = (in_ch.func == pcc_pkg::FUNC_TO_POLAR) &&
                    (in_ch.first_operand == '0) && (in_ch.second_operand == '0);
    if (in_ch.func == pcc_pkg::FUNC_TO_CART) begin
      x_nxt = a_x;
      y_nxt = '0;
      z_nxt = b_z;
      // angle beyond +-pi/2: turn by pi first
      if (b_z > pcc_pkg::HALF_PI_Q30) begin
        z_nxt = b_z - pcc_pkg::PI_Q30;
        x_nxt = -a_x;
      end else if (b_z < -pcc_pkg::HALF_PI_Q30) begin
        z_nxt = b_z + pcc_pkg::PI_Q30;
        x_nxt = -a_x;
      end
    end else begin
      x_nxt = a_x;
      y_nxt = b_y;
      z_nxt = '0;
      // left half plane: negate, start the angle at +-pi
      if (a_x[XW-1]) begin
        x_nxt = -a_x;
        y_nxt = -b_y;
        z_nxt = b_y[XW-1] ? -pcc_pkg::PI_Q30 : pcc_pkg::PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p_r <= '0;
    end else if (adv) begin
      ctl_p_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_p_r <= x_nxt;
      y_p_r <= y_nxt;
      z_p_r <= z_nxt;
    end
  end

  // ---- micro-rotation stages
  pcc_pkg::ctl_t        ctl_s [ITERATIONS+1];
  logic signed [XW-1:0] x_s   [ITERATIONS+1];
  logic signed [XW-1:0] y_s   [ITERATIONS+1];
  logic signed [ZW-1:0] z_s   [ITERATIONS+1];

  assign ctl_s[0] = ctl_p_r;
  assign x_s[0]   = x_p_r;
  assign y_s[0]   = y_p_r;
  assign z_s[0]   = z_p_r;

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
    pcc_stage #(
      .XW    (XW),
      .STAGE (g)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .ctl_in  (ctl_s[g]),
      .x_in    (x_s[g]),
      .y_in    (y_s[g]),
      .z_in    (z_s[g]),
      .ctl_out (ctl_s[g+1]),
      .x_out   (x_s[g+1]),
      .y_out   (y_s[g+1]),
      .z_out   (z_s[g+1])
    );
  end

  // ---- gain and formatting
  pcc_pkg::ctl_t                g_ctl;
  logic signed [DATA_WIDTH-1:0] g_first, g_second;

  pcc_gain #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_gain (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .ctl_in     (ctl_s[ITERATIONS]),
    .x_in       (x_s[ITERATIONS]),
    .y_in       (y_s[ITERATIONS]),
    .z_in       (z_s[ITERATIONS]),
    .ctl_out    (g_ctl),
    .first_out  (g_first),
    .second_out (g_second)
  );

  // ---- output register plus skid entry
  logic                         out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_first_r, out_first_nxt, out_second_r, out_second_nxt;
  logic signed [DATA_WIDTH-1:0] skid_first_r, skid_first_nxt, skid_second_r, skid_second_nxt;

  assign adv  = !skid_valid_r;
  assign push = adv && g_ctl.valid;
  assign pop  = out_valid_r && out_ch.ready;

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_first_nxt   = out_first_r;
    out_second_nxt  = out_second_r;
    skid_valid_nxt  = skid_valid_r;
    skid_first_nxt  = skid_first_r;
    skid_second_nxt = skid_second_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_first_nxt  = skid_first_r;
        out_second_nxt = skid_second_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || pop) begin
      out_valid_nxt  = push;
      out_first_nxt  = g_first;
      out_second_nxt = g_second;
    end else if (push) begin
      skid_valid_nxt  = 1'b1;
      skid_first_nxt  = g_first;
      skid_second_nxt = g_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_first_r   <= out_first_nxt;
    out_second_r  <= out_second_nxt;
    skid_first_r  <= skid_first_nxt;
    skid_second_r <= skid_second_nxt;
  end

  assign in_ch.ready          = adv;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.first_result  = out_first_r;
  assign out_ch.second_result = out_second_r;

endmodule

`default_nettype wire

// ===== src/pcc_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "polar_cartesian_converter_unit_assert.svh"

module pcc_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_first_result,
  input logic [DATA_WIDTH-1:0] out_second_result
);

  // a stalled result stays up
  `PCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // and keeps its value
  `PCC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_first_result) && $stable(out_second_result), "result changed while stalled")

  // input only backs up once a result is already waiting
  `PCC_ASSERT_NOW(a_full_has_out, !in_ready, out_valid, "input stalled with empty output")

  // taking a result always frees room for a new item
  `PCC_ASSERT_NEXT(a_pop_frees, out_valid && out_ready, in_ready, "input still stalled after a result was taken")

endmodule

bind polar_cartesian_converter_unit pcc_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_pcc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_first_result  (out_ch.first_result),
  .out_second_result (out_ch.second_result)
);

`default_nettype wire
